>>> rtl/msli_pkg.sv
// shared types and constants for the multiway sorted-list intersection block
`default_nettype none

package msli_pkg;

    localparam int OFS_W = 48;
    localparam int TAB_W = 16;
    localparam int MCNT_W = 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [OFS_W-1:0] ofs;
        logic [TAB_W-1:0] tab;
    } t_cand;

endpackage

`default_nettype wire

>>> rtl/multiway_sorted_list_intersect.sv
// top level of the multiway sorted-list intersection block
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  input   | in        | i_valid / o_ready   | func, has_element, node_offset, node_table,
//          |           |                     | list_end, final_list
//  output  | out       | o_valid / i_ready   | found, out_offset, out_table, last,
//          |           |                     | match_count, overflow
//
// a first-list item or an item without element is done at its transfer; a later-list element
// then walks the candidates one compare at a time (dropped candidates plus the deciding one),
// set by the single read port of the candidate store. a final list end then emits each survivor
// in turn (or one empty result), pausing while the output register is stalled.
// synchronous active-low reset clears pointers, count and overflow; no clearing pass.
// the output register lets the next run's items be taken while a result waits for transfer.
`default_nettype none

module multiway_sorted_list_intersect #(
    parameter int CAPACITY = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_func,
    input  wire                          i_has_element,
    input  wire  [msli_pkg::OFS_W-1:0]   i_node_offset,
    input  wire  [msli_pkg::TAB_W-1:0]   i_node_table,
    input  wire                          i_list_end,
    input  wire                          i_final_list,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_found,
    output logic [msli_pkg::OFS_W-1:0]   o_out_offset,
    output logic [msli_pkg::TAB_W-1:0]   o_out_table,
    output logic                         o_last,
    output logic [msli_pkg::MCNT_W-1:0]  o_match_count,
    output logic                         o_overflow
);
    import msli_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_wp, n_wp;
    logic              r_ovf, n_ovf;
    logic [OFS_W-1:0]  r_key, n_key;
    logic              r_lend, n_lend;
    logic              r_fin, n_fin;

    logic              r_o_valid, n_o_valid;
    logic              r_o_found, n_o_found;
    logic [OFS_W-1:0]  r_o_ofs, n_o_ofs;
    logic [TAB_W-1:0]  r_o_tab, n_o_tab;
    logic              r_o_last, n_o_last;
    logic [MCNT_W-1:0] r_o_mcnt, n_o_mcnt;
    logic              r_o_ovf, n_o_ovf;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_cand             mem_wdata;
    logic [AW-1:0]     mem_raddr;
    t_cand             mem_rdata;

    logic              in_xfer;
    logic              out_free;
    logic              merge_start;
    logic              merge_done;
    logic              cmp_lt;
    logic              cmp_eq;
    logic              rp_next_in;
    logic              list_done;
    logic              cur_lend;
    logic              cur_fin;
    logic              emit_start;
    logic              emit_last;
    logic              emit_done;
    logic [CW+MCNT_W-1:0] count_ext;

    assign o_ready     = (r_state == S_IDLE);
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;

    assign cmp_lt      = mem_rdata.ofs < r_key;
    assign cmp_eq      = mem_rdata.ofs == r_key;
    assign rp_next_in  = (r_rp + CW'(1)) < r_count;

    assign merge_start = in_xfer && i_func && i_has_element && (r_rp < r_count);
    assign merge_done  = (r_state == S_MERGE) && !(cmp_lt && rp_next_in);

    // an item finishes either at its transfer or at the end of its merge walk
    assign list_done   = (in_xfer && !merge_start) || merge_done;
    assign cur_lend    = (r_state == S_IDLE) ? i_list_end   : r_lend;
    assign cur_fin     = (r_state == S_IDLE) ? i_final_list : r_fin;
    assign emit_start  = list_done && cur_lend && cur_fin;

    assign emit_last   = (r_rp + CW'(1)) == r_count;
    assign emit_done   = (r_state == S_EMIT) && out_free &&
                         ((r_count == '0) || emit_last);

    assign count_ext   = {{MCNT_W{1'b0}}, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (merge_start) begin
                    n_state = S_MERGE;
                end else if (emit_start) begin
                    n_state = S_EMIT;
                end
            end
            S_MERGE: begin
                if (emit_start) begin
                    n_state = S_EMIT;
                end else if (merge_done) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count   = r_count;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_ovf     = r_ovf;
        n_key     = r_key;
        n_lend    = r_lend;
        n_fin     = r_fin;
        n_o_valid = r_o_valid && !i_ready;
        n_o_found = r_o_found;
        n_o_ofs   = r_o_ofs;
        n_o_tab   = r_o_tab;
        n_o_last  = r_o_last;
        n_o_mcnt  = r_o_mcnt;
        n_o_ovf   = r_o_ovf;
        mem_we    = 1'b0;
        mem_waddr = r_wp[AW-1:0];
        mem_wdata = mem_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key  = i_node_offset;
                    n_lend = i_list_end;
                    n_fin  = i_final_list;
                    if (!i_func) begin
                        if (i_has_element) begin
                            if (r_count < CW'(CAPACITY)) begin
                                mem_we        = 1'b1;
                                mem_waddr     = r_count[AW-1:0];
                                mem_wdata.ofs = i_node_offset;
                                mem_wdata.tab = i_node_table;
                                n_count       = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else if (!merge_start && i_list_end) begin
                        n_count = r_wp;
                        n_rp    = '0;
                        n_wp    = '0;
                    end
                    if (emit_start) begin
                        n_rp = '0;
                    end
                end
            end
            S_MERGE: begin
                if (cmp_lt) begin
                    n_rp = r_rp + CW'(1);
                end else if (cmp_eq) begin
                    // keep the candidate, compacted at the write pointer
                    mem_we    = 1'b1;
                    mem_waddr = r_wp[AW-1:0];
                    mem_wdata = mem_rdata;
                    n_wp      = r_wp + CW'(1);
                    n_rp      = r_rp + CW'(1);
                end
                if (merge_done && r_lend) begin
                    n_count = n_wp;
                    n_rp    = '0;
                    n_wp    = '0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_mcnt  = count_ext[MCNT_W-1:0];
                    n_o_ovf   = r_ovf;
                    if (r_count == '0) begin
                        n_o_found = 1'b0;
                        n_o_ofs   = '0;
                        n_o_tab   = '0;
                        n_o_last  = 1'b1;
                    end else begin
                        n_o_found = 1'b1;
                        n_o_ofs   = mem_rdata.ofs;
                        n_o_tab   = mem_rdata.tab;
                        n_o_last  = emit_last;
                        n_rp      = r_rp + CW'(1);
                    end
                    if (emit_done) begin
                        n_count = '0;
                        n_rp    = '0;
                        n_wp    = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_rp = r_rp;
            end
        endcase
    end

    // the read address follows the next read pointer so the registered read data matches the read pointer
    assign mem_raddr = (n_rp < CW'(CAPACITY)) ? n_rp[AW-1:0] : '0;

    msli_cand_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_lend    <= n_lend;
        r_fin     <= n_fin;
        r_o_found <= n_o_found;
        r_o_ofs   <= n_o_ofs;
        r_o_tab   <= n_o_tab;
        r_o_last  <= n_o_last;
        r_o_mcnt  <= n_o_mcnt;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_out_offset  = r_o_ofs;
    assign o_out_table   = r_o_tab;
    assign o_last        = r_o_last;
    assign o_match_count = r_o_mcnt;
    assign o_overflow    = r_o_ovf;

endmodule

`default_nettype wire

>>> rtl/msli_cand_store.sv
// candidate store: one-port-write, one-port-read memory with write-to-read forwarding
`default_nettype none

module msli_cand_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_we,
    input  wire  [AW-1:0]         i_waddr,
    input  wire  msli_pkg::t_cand i_wdata,
    input  wire  [AW-1:0]         i_raddr,
    output msli_pkg::t_cand       o_rdata
);
    import msli_pkg::*;

    t_cand       r_mem [DEPTH];
    t_cand       r_rdata;
    t_cand       r_fwd_data;
    logic        r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    // a read that hits the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

`default_nettype wire

>>> rtl/msli_checker.sv
// port-level checker for the multiway sorted-list intersection block, with its bind
`default_nettype none

module msli_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_ready,
    input  wire                          o_valid,
    input  wire                          i_ready,
    input  wire                          o_found,
    input  wire  [msli_pkg::OFS_W-1:0]   o_out_offset,
    input  wire  [msli_pkg::TAB_W-1:0]   o_out_table,
    input  wire                          o_last,
    input  wire  [msli_pkg::MCNT_W-1:0]  o_match_count
);
    import msli_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_offset) && $stable(o_last))
        else $error("result changed while stalled");

    // the empty result is a lone, zeroed, last result
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last && (o_match_count == '0) &&
                                (o_out_offset == '0) && (o_out_table == '0))
        else $error("malformed empty result");

    // survivors stream out back to back once a transfer completes
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_found && !o_last |=> o_valid && o_found)
        else $error("gap inside survivor stream");

    // no new input is taken while a run is still being emitted
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found && !o_last |-> !o_ready)
        else $error("input ready during emission");

endmodule

bind multiway_sorted_list_intersect msli_checker u_msli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_found       (o_found),
    .o_out_offset  (o_out_offset),
    .o_out_table   (o_out_table),
    .o_last        (o_last),
    .o_match_count (o_match_count)
);

`default_nettype wire
